// ===== hw/rtl/edd_pkg.sv =====
// Package for the RGB555 error diffusion dither: pixel request types,
// register indexes, reset values and the per-channel dither arithmetic.
// No dependencies.
`timescale 1ns / 1ps

package edd_pkg;

  localparam int unsigned CfgW        = 13;
  localparam int unsigned ErrW        = 12;
  localparam int unsigned MaxWidthDef = 4096;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned WidthRst    = 640;
  localparam int unsigned HeightRst   = 480;
  localparam int unsigned RowW        = $clog2(MaxHeight);

  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_in_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] out_alpha;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] q;
    logic [3:0] e;
  } ch_res_t;

  // floor(c + e * k / 16), clamped to 0..255
  function automatic logic [7:0] add_err(logic [7:0] c, logic signed [3:0] e,
                                         logic [2:0] k);
    logic signed [13:0] v;
    v = $signed({2'b00, c, 4'b0000}) + (14'(e) * $signed({11'd0, k}));
    if (v < 0) begin
      add_err = 8'd0;
    end else if (v[13:12] != 2'b00) begin
      add_err = 8'hFF;
    end else begin
      add_err = v[11:4];
    end
  endfunction

  function automatic ch_res_t dither_ch(logic [7:0] c, logic [3:0] al, logic [3:0] ab,
                                        logic [3:0] ar, logic [3:0] lf);
    logic [7:0] v;
    ch_res_t    r;
    v   = add_err(c, $signed(al), 3'd1);
    v   = add_err(v, $signed(ab), 3'd5);
    v   = add_err(v, $signed(ar), 3'd3);
    v   = add_err(v, $signed(lf), 3'd7);
    r.q = {v[7:3], v[7:5]};
    r.e = {1'b0, v[2:0]} - {1'b0, v[7:5]};
    dither_ch = r;
  endfunction

endpackage

// ===== hw/rtl/error_diffusion_dither_rgb555.sv =====
// Floyd-Steinberg style error diffusion from RGBA8888 to RGB555 levels.
// Depends on edd_pkg; holds the previous row's errors in a local memory.
//
// Usage: pixels enter in raster order on the in_* valid/ready channel and
// leave, one result request per pixel, on the out_* valid/ready channel.
// image_width and image_height are set through the cfg_* write port while
// the block is idle; any write restarts the frame at column 0, row 0.
// Path: an accepted request passes the row memory read stage, then the output
// register, which drives out_valid_o.
// Throughput: one pixel per cycle while out_ready_i is high. The left error loop
// closes through the dither stage and left_q; the row memory has two read ports
// (current and right-hand column) and one write port, with a bypass for a
// write and a read of the same entry in the same cycle (widths 1 and 2).
// Stalls: with out_ready_i low the output register and the stage behind it
// hold, and in_ready_o drops once both are full; nothing is lost.
// Reset: counters and error registers clear, sizes go to 640 x 480. The
// row memory needs no clearing, as row 0 never reads it.
`timescale 1ns / 1ps

module error_diffusion_dither_rgb555
  import edd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pix_in_t         in_pix_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pix_out_t        out_pix_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned AW       = $clog2(MAX_WIDTH);
  localparam int unsigned WLastRst = ((WidthRst > MAX_WIDTH) ? MAX_WIDTH : WidthRst) - 1;
  localparam int unsigned HLastRst = HeightRst - 1;

  logic [AW-1:0]   w_last_q;
  logic [RowW-1:0] h_last_q;
  logic [AW-1:0]   x_q, x_d;
  logic [RowW-1:0] y_q, y_d;

  logic            s1_valid_q;
  pix_in_t         s1_pix_q;
  logic [AW-1:0]   s1_x_q;
  logic            s1_row0_q, s1_col0_q, s1_last_q, s1_fend_q;

  logic [ErrW-1:0] rd0_q, rd1_q, fwd_data_q;
  logic            fwd0_q, fwd1_q;
  logic [ErrW-1:0] left_q, aleft_q;

  logic            out_valid_q;
  pix_out_t        out_q, out_d;

  logic [ErrW-1:0] mem [MAX_WIDTH];

  logic            in_acc, s1_adv, x_last;
  logic [AW-1:0]   rd_addr1;
  logic [ErrW-1:0] above_raw, above, abr, abl, lft, err_w;
  logic [2:0][7:0] cin;
  logic [2:0][7:0] qout;
  ch_res_t         chr;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign x_last   = (x_q == w_last_q);
  assign rd_addr1 = x_last ? x_q : x_q + AW'(1);

  always_comb begin
    x_d = x_q + AW'(1);
    y_d = y_q;
    if (x_last) begin
      x_d = '0;
      y_d = (y_q == h_last_q) ? '0 : y_q + RowW'(1);
    end
  end

  // stage 1: dither with errors from above and left
  assign above_raw = fwd0_q ? fwd_data_q : rd0_q;
  assign above     = s1_row0_q ? '0 : above_raw;
  assign abr       = (s1_row0_q || s1_last_q) ? '0 : (fwd1_q ? fwd_data_q : rd1_q);
  assign abl       = (s1_row0_q || s1_col0_q) ? '0 : aleft_q;
  assign lft       = s1_col0_q ? '0 : left_q;
  assign cin       = {s1_pix_q.blue, s1_pix_q.green, s1_pix_q.red};

  always_comb begin
    err_w = '0;
    qout  = cin;
    chr   = '0;
    if (s1_pix_q.alpha != 8'd0) begin
      for (int ch = 0; ch < 3; ch++) begin
        chr = dither_ch(cin[ch], abl[4*ch +: 4], above[4*ch +: 4], abr[4*ch +: 4],
                        lft[4*ch +: 4]);
        qout[ch]           = chr.q;
        err_w[4*ch +: 4]   = chr.e;
      end
    end
    out_d.out_red   = qout[0];
    out_d.out_green = qout[1];
    out_d.out_blue  = qout[2];
    out_d.out_alpha = (s1_pix_q.alpha != 8'd0) ? 8'hFF : 8'h00;
    out_d.frame_end = s1_fend_q;
  end

  // row error memory, read ahead at request accept
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_x_q] <= err_w;
    end
    if (in_acc) begin
      rd0_q      <= mem[x_q];
      rd1_q      <= mem[rd_addr1];
      fwd0_q     <= s1_adv && (s1_x_q == x_q);
      fwd1_q     <= s1_adv && (s1_x_q == rd_addr1);
      fwd_data_q <= err_w;
      s1_pix_q   <= in_pix_i;
      s1_x_q     <= x_q;
      s1_row0_q  <= (y_q == '0);
      s1_col0_q  <= (x_q == '0);
      s1_last_q  <= x_last;
      s1_fend_q  <= x_last && (y_q == h_last_q);
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q    <= AW'(WLastRst);
      h_last_q    <= RowW'(HLastRst);
      x_q         <= '0;
      y_q         <= '0;
      left_q      <= '0;
      aleft_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        x_q <= x_d;
        y_q <= y_d;
      end
      if (s1_adv) begin
        left_q  <= err_w;
        aleft_q <= above_raw;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageWidth: begin
            if (cfg_data_i == '0) begin
              w_last_q <= '0;
            end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
              w_last_q <= AW'(MAX_WIDTH - 1);
            end else begin
              w_last_q <= AW'(32'(cfg_data_i) - 32'd1);
            end
          end
          CfgImageHeight: begin
            if (cfg_data_i == '0) begin
              h_last_q <= '0;
            end else if (32'(cfg_data_i) > 32'(MaxHeight)) begin
              h_last_q <= RowW'(MaxHeight - 1);
            end else begin
              h_last_q <= RowW'(32'(cfg_data_i) - 32'd1);
            end
          end
          default: begin
          end
        endcase
        x_q     <= '0;
        y_q     <= '0;
        left_q  <= '0;
        aleft_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for error_diffusion_dither_rgb555: table-driven and random
// pixel requests in raster order, checked against pinned table results or a behavioural dither predictor.
// Depends on edd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
  import edd_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned RandomItems = 250;   // minimum pixels per phase
  localparam int unsigned MaxReports  = 10;

  // One stimulus row: a size write pair or a pixel request.
  typedef struct packed {
    logic            is_cfg;
    logic [CfgW-1:0] wv;
    logic [CfgW-1:0] hv;
    logic [31:0]     pix;    // alpha, blue, green, red
    logic            known;
    logic [32:0]     want;   // frame_end, alpha, blue, green, red
  } step_t;

  localparam int unsigned NumSteps = 21;
  localparam step_t Directed [NumSteps] = '{
    // after reset, 640 x 480
    '{1'b0, 13'd0, 13'd0, 32'hFF_00_00_00, 1'b1, 33'h0_FF_00_00_00},
    '{1'b0, 13'd0, 13'd0, 32'hFF_FF_FF_FF, 1'b1, 33'h0_FF_FF_FF_FF},
    '{1'b0, 13'd0, 13'd0, 32'h00_38_22_0C, 1'b1, 33'h0_00_38_22_0C},
    '{1'b0, 13'd0, 13'd0, 32'h01_C8_64_07, 1'b0, 33'h0},
    // single pixel frames
    '{1'b1, 13'd1, 13'd1, 32'h0, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'h80_FA_0D_64, 1'b1, 33'h1_FF_FF_08_63},
    '{1'b1, 13'd0, 13'd0, 32'h0, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'h00_AB_CD_EF, 1'b1, 33'h1_00_AB_CD_EF},
    // 3 x 2: every neighbour, clamping at both ends
    '{1'b1, 13'd3, 13'd2, 32'h0, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'hFF_07_07_07, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'hFF_F8_F8_F8, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'hFF_07_F8_00, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'hFF_FF_FF_FF, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'h00_11_22_33, 1'b1, 33'h0_00_11_22_33},
    '{1'b0, 13'd0, 13'd0, 32'hFF_00_00_00, 1'b0, 33'h0},
    // oversize registers act as the maximum
    '{1'b1, 13'd8191, 13'd8191, 32'h0, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'hFF_80_80_80, 1'b1, 33'h0_FF_84_84_84},
    '{1'b0, 13'd0, 13'd0, 32'hFF_FF_00_7F, 1'b0, 33'h0},
    '{1'b1, 13'd4096, 13'd4096, 32'h0, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'hFF_12_34_56, 1'b0, 33'h0},
    '{1'b0, 13'd0, 13'd0, 32'h00_FF_FF_FF, 1'b1, 33'h0_00_FF_FF_FF}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  pix_in_t         in_pix_i;
  logic            out_valid_o;
  logic            out_ready_i;
  pix_out_t        out_pix_o;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  // pinned result for table rows, held with the request
  logic            pinned;
  pix_out_t        pinned_want;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_cnt;
  int unsigned recv_cnt;
  int unsigned quiet_cnt;
  int unsigned fail_cnt;

  pix_out_t dither_q [$];

  // predictor state
  logic [11:0]     row_err [MaxWidthDef];
  logic [11:0]     left_err;
  logic [23:0]     above_win;
  int unsigned     col_cnt;
  int unsigned     row_cnt;
  logic [CfgW-1:0] width_reg;
  logic [CfgW-1:0] height_reg;

  error_diffusion_dither_rgb555 u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pix_i    (in_pix_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pix_o   (out_pix_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int err_nibble(logic [11:0] packed_err, int ch);
    logic signed [3:0] e;
    int v;
    e = packed_err[4*ch +: 4];
    v = e;
    return v;
  endfunction

  // floor(c + e * k / 16), held to 0..255
  function automatic int take_err(int c, int e, int k);
    int v;
    v = c * 16 + e * k;
    if (v < 0) return 0;
    v = v >> 4;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic void restart_raster();
    left_err  = '0;
    above_win = '0;
    col_cnt   = 0;
    row_cnt   = 0;
  endfunction

  function automatic pix_out_t dither_predict(pix_in_t p);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    logic [11:0] ab;
    logic [11:0] al;
    logic [11:0] ar;
    logic [11:0] lf;
    logic [11:0] mine;
    logic [7:0]  chan [3];
    int          v;
    int          q;
    pix_out_t    r;
    w = (width_reg == 0) ? 1 : ((width_reg > MaxWidthDef) ? MaxWidthDef : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MaxHeight) ? MaxHeight : height_reg);
    x = col_cnt;
    y = row_cnt;
    ab = '0;
    al = '0;
    ar = '0;
    lf = '0;
    mine = '0;
    chan[0] = p.red;
    chan[1] = p.green;
    chan[2] = p.blue;
    if (y > 0) begin
      ab = row_err[x];
      if (x > 0) al = above_win[11:0];
      if (x + 1 < w) ar = row_err[x+1];
    end
    if (x > 0) lf = left_err;
    if (p.alpha != 8'h00) begin
      for (int ch = 0; ch < 3; ch++) begin
        v = chan[ch];
        v = take_err(v, err_nibble(al, ch), 1);
        v = take_err(v, err_nibble(ab, ch), 5);
        v = take_err(v, err_nibble(ar, ch), 3);
        v = take_err(v, err_nibble(lf, ch), 7);
        q = (v & 'hF8) | (v >> 5);
        mine[4*ch +: 4] = 4'(v - q);
        chan[ch] = 8'(q);
      end
    end
    r.out_red   = chan[0];
    r.out_green = chan[1];
    r.out_blue  = chan[2];
    r.out_alpha = (p.alpha != 8'h00) ? 8'hFF : 8'h00;
    r.frame_end = (x + 1 >= w) && (y + 1 >= h);
    above_win  = {ar, ab};
    row_err[x] = mine;
    left_err   = mine;
    if (x + 1 >= w) begin
      restart_raster();
      row_cnt = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
    return r;
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p = $urandom;
    case ($urandom_range(7))
      0: p.alpha = 8'h00;
      1, 2, 3: p.alpha = 8'hFF;
      default: ;
    endcase
    // near the quantiser's ends, where clamping bites
    if ($urandom_range(3) == 0) begin
      p.red   = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(248, 255));
      p.green = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(248, 255));
      p.blue  = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(248, 255));
    end
    return p;
  endfunction

  task automatic send_pixel(input pix_in_t p, input logic pin, input pix_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_pix_i    <= p;
    pinned      <= pin;
    pinned_want <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // both sizes, once every request has come back
  task automatic set_size(input logic [CfgW-1:0] wv, input logic [CfgW-1:0] hv);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (recv_cnt != sent_cnt) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgImageWidth;
    cfg_data_i <= wv;
    @(posedge clk_i);
    cfg_idx_i  <= CfgImageHeight;
    cfg_data_i <= hv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    pix_out_t want;
    pix_out_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt <= recv_cnt + 1;
        got = out_pix_o;
        if (dither_q.size() == 0) begin
          if (fail_cnt < MaxReports)
            $display("unexpected result request: r=%0d g=%0d b=%0d a=%0d fe=%0b",
                     got.out_red, got.out_green, got.out_blue, got.out_alpha,
                     got.frame_end);
          fail_cnt++;
        end else begin
          want = dither_q.pop_front();
          if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
              got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
              got.frame_end !== want.frame_end) begin
            if (fail_cnt < MaxReports)
              $display("mismatch: exp %0d/%0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0d/%0b",
                       want.out_red, want.out_green, want.out_blue, want.out_alpha,
                       want.frame_end, got.out_red, got.out_green, got.out_blue,
                       got.out_alpha, got.frame_end);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = dither_predict(in_pix_i);
        dither_q.insert(dither_q.size(), pinned ? pinned_want : want);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgImageWidth) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        restart_raster();
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cnt < QuietLimit) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned wv;
    int unsigned hv;
    int unsigned n;
    int unsigned done;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_pix_i      = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgImageWidth;
    cfg_data_i    = '0;
    pinned        = 1'b0;
    pinned_want   = '0;
    sent_cnt      = 0;
    recv_cnt      = 0;
    quiet_cnt     = 0;
    fail_cnt      = 0;
    width_reg     = WidthRst;
    height_reg    = HeightRst;
    send_idle_pct = 22;
    recv_idle_pct = 51;
    restart_raster();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i]) begin
      if (Directed[i].is_cfg) set_size(Directed[i].wv, Directed[i].hv);
      else send_pixel(pix_in_t'(Directed[i].pix), Directed[i].known,
                      pix_out_t'(Directed[i].want));
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : ((ph == 1) ? 51 : 0);
      recv_idle_pct = (ph == 0) ? 51 : ((ph == 1) ? 22 : 0);
      done = 0;
      while (done < RandomItems) begin
        if ($urandom_range(7) == 0) begin
          wv = $urandom_range(9, 80);
          hv = $urandom_range(1, 2);
          n  = wv * hv;
        end else begin
          wv = $urandom_range(1, 8);
          hv = $urandom_range(1, 5);
          n  = wv * hv * $urandom_range(1, 3);
        end
        // a partial frame now and then, cut short by the next size write
        if ($urandom_range(3) == 0) n += $urandom_range(1, wv);
        set_size(wv, hv);
        repeat (n) send_pixel(rand_pixel(), 1'b0, '0);
        done += n;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (recv_cnt != sent_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && dither_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
